[sv/cprt_pkg.sv]
// Package for the correctable error page retirement tracker.
// Holds table sizes, field widths and outcome codes; no dependencies.
package cprt_pkg;
    localparam int LINE_ENTRIES = 256;
    localparam int PAGE_ENTRIES = 64;
    localparam int PAGE_SHIFT   = 12;
    localparam int LINE_SHIFT   = 6;
    localparam int ADDR_W  = 48;
    localparam int LINE_W  = ADDR_W - LINE_SHIFT;
    localparam int PAGE_W  = ADDR_W - PAGE_SHIFT;
    localparam int RPAGE_W = 36;
    localparam int LIDX_W  = $clog2(LINE_ENTRIES);
    localparam int PIDX_W  = $clog2(PAGE_ENTRIES);
    localparam int LCNT_W  = LIDX_W + 1;
    localparam int PCNT_W  = PIDX_W + 1;
    localparam int REMOVED_W = 9;

    typedef enum logic [2:0] {
        OUT_KNOWN   = 3'd0,
        OUT_FIRST   = 3'd1,
        OUT_ADDED   = 3'd2,
        OUT_RETIRED = 3'd3,
        OUT_FULL    = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        CFG_RETIRE   = 2'd0,
        CFG_BASE_THR = 2'd1,
        CFG_BASE_MODE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] retire_threshold;
        logic [7:0] baseline_threshold;
        logic       baseline_mode;
    } cfg_t;
endpackage

[sv/ce_page_retirement_tracker_unit.sv]
// Top level of the correctable error page retirement tracker.
// Holds the scan sequencer, the line and page tables; depends on cprt_pkg, cprt_cfg.
//
//  channel | ports                         | direction
//  s_      | s_valid s_ready s_phys_addr   | error address in
//  m_      | m_valid m_ready m_outcome ... | one result per address
//  cfg_    | cfg_valid cfg_ready index data| register writes
//
// Each item passes through these steps in order: accept, a line table scan, a page table
// scan, decide, write and present the result (the write is skipped when nothing is
// written). A retirement replaces the write with a line table sweep. Each table has a
// single read port, so every scan reads its entries in turn. Reset is synchronous and
// clears all valid bits at once. The result waits in an output register and
// the next transfer is taken only after it has been delivered.
module ce_page_retirement_tracker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [47:0] s_phys_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_outcome,
    output logic [7:0]  m_page_errors,
    output logic [35:0] m_retired_page,
    output logic [8:0]  m_lines_removed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import cprt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LSCAN = 7'b0000010,
        ST_PSCAN = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_SWEEP = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    cfg_t cfg;
    cprt_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
    );

    logic [LINE_W-1:0] line_mem [LINE_ENTRIES];
    logic [PAGE_W-1:0] tag_mem [PAGE_ENTRIES];
    logic [7:0]        cnt_mem [PAGE_ENTRIES];
    logic [LINE_ENTRIES-1:0] lvalid_reg;
    logic [PAGE_ENTRIES-1:0] pvalid_reg;

    state_t state_reg;
    logic [LINE_W-1:0] line_reg;
    logic [LCNT_W-1:0] lptr_reg;
    logic [LIDX_W-1:0] lprev_reg;
    logic              lrd_reg;
    logic [LINE_W-1:0] lrdata_reg;
    logic [PCNT_W-1:0] pptr_reg;
    logic [PIDX_W-1:0] pprev_reg;
    logic              prd_reg;
    logic [PAGE_W-1:0] trdata_reg;
    logic [7:0]        crdata_reg;
    logic              lhit_reg, phit_reg, lfree_ok_reg, pfree_ok_reg;
    logic [LIDX_W-1:0] lfree_reg;
    logic [PIDX_W-1:0] pidx_reg, pfree_reg;
    logic [7:0]        cur_reg;
    logic [REMOVED_W-1:0] removed_reg;
    logic [2:0]        outcome_reg;
    logic [7:0]        perr_reg;
    logic [35:0]       rpage_reg;

    logic [PAGE_W-1:0] page_w;
    logic [7:0]        next_w, thr_w;
    logic              lhit_w, phit_w;

    assign page_w = line_reg[LINE_W-1 -: PAGE_W];
    assign next_w = (cur_reg == 8'hFF) ? 8'hFF : cur_reg + 8'd1;
    assign thr_w  = cfg.baseline_mode ? cfg.baseline_threshold : cfg.retire_threshold;
    assign lhit_w = lrd_reg && lvalid_reg[lprev_reg] && (lrdata_reg == line_reg);
    assign phit_w = prd_reg && pvalid_reg[pprev_reg] && (trdata_reg == page_w);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_outcome = outcome_reg;
    assign m_page_errors = perr_reg;
    assign m_retired_page = rpage_reg;
    assign m_lines_removed = removed_reg;

    always_ff @(posedge aclk) begin
        lrdata_reg <= line_mem[lptr_reg[LIDX_W-1:0]];
        trdata_reg <= tag_mem[pptr_reg[PIDX_W-1:0]];
        crdata_reg <= cnt_mem[pptr_reg[PIDX_W-1:0]];
        if (state_reg == ST_WRITE) begin
            if (!phit_reg) begin
                tag_mem[pfree_reg] <= page_w;
            end
            cnt_mem[phit_reg ? pidx_reg : pfree_reg] <= next_w;
            if (!lhit_reg) begin
                line_mem[lfree_reg] <= line_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            lvalid_reg <= '0;
            pvalid_reg <= '0;
            lrd_reg    <= 1'b0;
            prd_reg    <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        line_reg     <= s_phys_addr[ADDR_W-1:LINE_SHIFT];
                        lptr_reg     <= '0;
                        pptr_reg     <= '0;
                        lrd_reg      <= 1'b0;
                        prd_reg      <= 1'b0;
                        lhit_reg     <= 1'b0;
                        phit_reg     <= 1'b0;
                        lfree_ok_reg <= 1'b0;
                        pfree_ok_reg <= 1'b0;
                        cur_reg      <= 8'd0;
                        removed_reg  <= '0;
                        state_reg    <= ST_LSCAN;
                    end
                end
                ST_LSCAN: begin
                    if (lhit_w) begin
                        lhit_reg <= 1'b1;
                    end
                    if (lrd_reg && !lvalid_reg[lprev_reg] && !lfree_ok_reg) begin
                        lfree_ok_reg <= 1'b1;
                        lfree_reg    <= lprev_reg;
                    end
                    lprev_reg <= lptr_reg[LIDX_W-1:0];
                    if (lptr_reg == LCNT_W'(LINE_ENTRIES)) begin
                        lrd_reg   <= 1'b0;
                        state_reg <= ST_PSCAN;
                    end else begin
                        lrd_reg  <= 1'b1;
                        lptr_reg <= lptr_reg + 1'b1;
                    end
                end
                ST_PSCAN: begin
                    if (phit_w && !phit_reg) begin
                        phit_reg <= 1'b1;
                        pidx_reg <= pprev_reg;
                        cur_reg  <= crdata_reg;
                    end
                    if (prd_reg && !pvalid_reg[pprev_reg] && !pfree_ok_reg) begin
                        pfree_ok_reg <= 1'b1;
                        pfree_reg    <= pprev_reg;
                    end
                    pprev_reg <= pptr_reg[PIDX_W-1:0];
                    if (pptr_reg == PCNT_W'(PAGE_ENTRIES)) begin
                        prd_reg   <= 1'b0;
                        state_reg <= ST_DECIDE;
                    end else begin
                        prd_reg  <= 1'b1;
                        pptr_reg <= pptr_reg + 1'b1;
                    end
                end
                ST_DECIDE: begin
                    perr_reg  <= cur_reg;
                    rpage_reg <= '0;
                    if (!cfg.baseline_mode && lhit_reg) begin
                        outcome_reg <= OUT_KNOWN;
                        state_reg   <= ST_OUT;
                    end else if (next_w >= thr_w) begin
                        outcome_reg <= OUT_RETIRED;
                        perr_reg    <= next_w;
                        rpage_reg   <= RPAGE_W'(page_w);
                        removed_reg <= lhit_reg ? 9'd0 : 9'd1;
                        if (phit_reg) begin
                            pvalid_reg[pidx_reg] <= 1'b0;
                        end
                        lptr_reg  <= '0;
                        lrd_reg   <= 1'b0;
                        state_reg <= ST_SWEEP;
                    end else if (!(phit_reg || pfree_ok_reg) ||
                                 !(lhit_reg || lfree_ok_reg)) begin
                        outcome_reg <= OUT_FULL;
                        state_reg   <= ST_OUT;
                    end else begin
                        outcome_reg <= (next_w == 8'd1) ? OUT_FIRST : OUT_ADDED;
                        perr_reg    <= next_w;
                        state_reg   <= ST_WRITE;
                    end
                end
                ST_SWEEP: begin
                    if (lrd_reg && lvalid_reg[lprev_reg] &&
                        lrdata_reg[LINE_W-1 -: PAGE_W] == page_w) begin
                        lvalid_reg[lprev_reg] <= 1'b0;
                        removed_reg <= removed_reg + 9'd1;
                    end
                    lprev_reg <= lptr_reg[LIDX_W-1:0];
                    if (lptr_reg == LCNT_W'(LINE_ENTRIES)) begin
                        lrd_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end else begin
                        lrd_reg  <= 1'b1;
                        lptr_reg <= lptr_reg + 1'b1;
                    end
                end
                ST_WRITE: begin
                    if (!phit_reg) begin
                        pvalid_reg[pfree_reg] <= 1'b1;
                    end
                    if (!lhit_reg) begin
                        lvalid_reg[lfree_reg] <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        removed_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and output both open");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_outcome))
        else $error("result changed while stalled");
    a_removed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome != OUT_RETIRED |-> m_lines_removed == 9'd0 &&
        m_retired_page == 36'd0) else $error("retire fields set without retirement");
    a_retired_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome == OUT_RETIRED |-> m_page_errors != 8'd0)
        else $error("retirement with zero count");
`endif
endmodule

[sv/cprt_cfg.sv]
// Configuration register file of the page retirement tracker.
// Depends on cprt_pkg.
module cprt_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output cprt_pkg::cfg_t cfg
);
    import cprt_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retire_threshold   <= 8'd4;
            cfg_reg.baseline_threshold <= 8'd4;
            cfg_reg.baseline_mode      <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RETIRE:    cfg_reg.retire_threshold   <= cfg_data;
                CFG_BASE_THR:  cfg_reg.baseline_threshold <= cfg_data;
                CFG_BASE_MODE: cfg_reg.baseline_mode      <= cfg_data[0];
                default: ;
            endcase
        end
    end
endmodule

[tb/sv/ce_page_retirement_tracker_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for ce_page_retirement_tracker_unit with its own table predictor.
// Drives error addresses and register writes over valid/ready channels; depends on cprt_pkg.
module ce_page_retirement_tracker_unit_test;
    import cprt_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        outcome_t    outcome;
        logic [7:0]  errs;
        logic [35:0] page;
        logic [8:0]  removed;
    } verdict_t;

    typedef struct {
        logic [47:0] addr;
        bit          typed;
        verdict_t    want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_phys_addr = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_outcome;
    logic [7:0]  m_page_errors;
    logic [35:0] m_retired_page;
    logic [8:0]  m_lines_removed;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // Shadow copy of the tables and registers.
    logic [41:0] line_tab [LINE_ENTRIES];
    bit          line_ok  [LINE_ENTRIES];
    logic [35:0] page_tab [PAGE_ENTRIES];
    logic [7:0]  page_cnt [PAGE_ENTRIES];
    bit          page_ok  [PAGE_ENTRIES];
    logic [7:0]  thr_retire = 8'd4;
    logic [7:0]  thr_base = 8'd4;
    bit          mode_base = 1'b0;

    verdict_t    pending_q[$];
    logic [47:0] recent[$];
    logic [35:0] page_pool[$];
    int          line_span = 7;
    bit          no_idle = 1'b0;
    int          mismatches = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_retired = 0;
    int          n_full = 0;

    ce_page_retirement_tracker_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_phys_addr(s_phys_addr),
        .m_valid(m_valid), .m_ready(m_ready), .m_outcome(m_outcome),
        .m_page_errors(m_page_errors), .m_retired_page(m_retired_page),
        .m_lines_removed(m_lines_removed),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("FAIL ce_page_retirement_tracker_unit");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    function automatic verdict_t track_error(input logic [47:0] addr);
        logic [41:0] line;
        logic [35:0] page;
        int li, pi, pf, lf, cur, nxt, thr, removed;
        verdict_t v;
        line = addr[47:6];
        page = addr[47:12];
        li = -1;
        pi = -1;
        pf = -1;
        lf = -1;
        removed = 0;
        for (int i = 0; i < LINE_ENTRIES; i++)
            if (li < 0 && line_ok[i] && line_tab[i] == line) li = i;
        for (int i = 0; i < PAGE_ENTRIES; i++)
            if (pi < 0 && page_ok[i] && page_tab[i] == page) pi = i;
        cur = (pi >= 0) ? page_cnt[pi] : 0;
        v = '{OUT_KNOWN, cur[7:0], 36'd0, 9'd0};
        if (!mode_base && li >= 0) return v;
        nxt = (cur < 255) ? cur + 1 : 255;
        thr = mode_base ? thr_base : thr_retire;
        if (nxt >= thr) begin
            for (int i = 0; i < LINE_ENTRIES; i++)
                if (line_ok[i] && line_tab[i][41:6] == page) begin
                    line_ok[i] = 1'b0;
                    removed++;
                end
            if (li < 0) removed++;
            if (pi >= 0) page_ok[pi] = 1'b0;
            v = '{OUT_RETIRED, nxt[7:0], page, removed[8:0]};
            return v;
        end
        for (int i = PAGE_ENTRIES - 1; i >= 0; i--) if (!page_ok[i]) pf = i;
        for (int i = LINE_ENTRIES - 1; i >= 0; i--) if (!line_ok[i]) lf = i;
        if (pi >= 0) pf = pi;
        if (li >= 0) lf = li;
        if (pf < 0 || lf < 0) begin
            v.outcome = OUT_FULL;
            return v;
        end
        page_ok[pf] = 1'b1;
        page_tab[pf] = page;
        page_cnt[pf] = nxt[7:0];
        line_ok[lf] = 1'b1;
        line_tab[lf] = line;
        v.outcome = (nxt == 1) ? OUT_FIRST : OUT_ADDED;
        v.errs = nxt[7:0];
        return v;
    endfunction

    task automatic send_error(input logic [47:0] addr, input bit typed, input verdict_t want);
        int gap;
        verdict_t v;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_phys_addr <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        v = track_error(addr);
        pending_q = {pending_q, (typed ? want : v)};
        recent = {recent, addr};
        if (recent.size() > 16) void'(recent.pop_front());
        n_items++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_RETIRE:    thr_retire = data;
            CFG_BASE_THR:  thr_base = data;
            CFG_BASE_MODE: mode_base = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_phase(input logic [7:0] rt, input logic [7:0] bt, input bit bm,
                             input int pool_n, input int span);
        logic [63:0] r;
        drain_results();
        write_reg(CFG_RETIRE, rt);
        write_reg(CFG_BASE_THR, bt);
        write_reg(CFG_BASE_MODE, {7'($urandom), bm});
        page_pool.delete();
        for (int i = 0; i < pool_n; i++) begin
            r = {$urandom, $urandom};
            page_pool = {page_pool, r[35:0]};
        end
        line_span = span;
    endtask

    function automatic logic [47:0] pick_addr();
        logic [63:0] r;
        int roll;
        r = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 12 || page_pool.size() == 0) return r[47:0];
        if (roll < 27 && recent.size() != 0) return recent[$urandom_range(0, recent.size() - 1)];
        return {page_pool[$urandom_range(0, page_pool.size() - 1)],
                6'($urandom_range(0, line_span)), r[5:0]};
    endfunction

    task automatic run_random(input int count);
        verdict_t none;
        none = '{OUT_KNOWN, 8'd0, 36'd0, 9'd0};
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_error(pick_addr(), 1'b0, none);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            verdict_t e;
            n_results++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result, outcome", 0, m_outcome);
            end else begin
                e = pending_q.pop_front();
                if (m_outcome != e.outcome) report_mismatch("outcome", e.outcome, m_outcome);
                if (m_page_errors != e.errs) report_mismatch("page_errors", e.errs, m_page_errors);
                if (m_retired_page != e.page)
                    report_mismatch("retired_page", e.page, m_retired_page);
                if (m_lines_removed != e.removed)
                    report_mismatch("lines_removed", e.removed, m_lines_removed);
                if (e.outcome == OUT_RETIRED) n_retired++;
                if (e.outcome == OUT_FULL) n_full++;
            end
        end
    end

    initial begin
        dir_row_t rows[15];
        verdict_t none;
        none = '{OUT_KNOWN, 8'd0, 36'd0, 9'd0};
        rows = '{
            '{48'h0000_0000_0000, 1'b1, '{OUT_FIRST,   8'd1, 36'd0, 9'd0}},
            '{48'h0000_0000_0000, 1'b1, '{OUT_KNOWN,   8'd1, 36'd0, 9'd0}},
            '{48'h0000_0000_003F, 1'b1, '{OUT_KNOWN,   8'd1, 36'd0, 9'd0}},
            '{48'hFFFF_FFFF_FFFF, 1'b1, '{OUT_FIRST,   8'd1, 36'd0, 9'd0}},
            '{48'h0000_0000_0040, 1'b1, '{OUT_ADDED,   8'd2, 36'd0, 9'd0}},
            '{48'h0000_0000_0080, 1'b1, '{OUT_ADDED,   8'd3, 36'd0, 9'd0}},
            '{48'h0000_0000_0FFF, 1'b1, '{OUT_RETIRED, 8'd4, 36'd0, 9'd4}},
            '{48'h0000_0000_0000, 1'b1, '{OUT_FIRST,   8'd1, 36'd0, 9'd0}},
            '{48'hFFFF_FFFF_FFC0, 1'b1, '{OUT_KNOWN,   8'd1, 36'd0, 9'd0}},
            '{48'hFFFF_FFFF_F000, 1'b1, '{OUT_ADDED,   8'd2, 36'd0, 9'd0}},
            '{48'hAAAA_AAAA_AAAA, 1'b0, none},
            '{48'h5555_5555_5555, 1'b0, none},
            '{48'h8000_0000_0000, 1'b0, none},
            '{48'h0000_0000_1000, 1'b0, none},
            '{48'h7FFF_FFFF_FFFF, 1'b0, none}
        };
        for (int i = 0; i < LINE_ENTRIES; i++) line_ok[i] = 1'b0;
        for (int i = 0; i < PAGE_ENTRIES; i++) page_ok[i] = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_error(rows[i].addr, rows[i].typed, rows[i].want);

        set_phase(8'd4, 8'd4, 1'b0, 24, 7);
        run_random(110);
        // The sender holds off here until every outstanding transfer has returned.
        set_phase(8'd200, 8'd200, 1'b0, 90, 3);
        write_reg(CFG_UNUSED, 8'hFF);
        run_random(150);
        set_phase(8'd255, 8'd255, 1'b0, 8, 63);
        run_random(300);
        set_phase(8'd0, 8'd0, 1'b1, 16, 7);
        run_random(60);
        set_phase(8'($urandom_range(1, 15)), 8'($urandom_range(1, 15)), 1'b1, 16, 7);
        run_random(150);
        set_phase(8'd1, 8'd255, 1'b0, 20, 15);
        run_random(80);
        set_phase(8'd3, 8'd1, 1'b0, 20, 7);
        run_random(80);

        drain_results();
        repeat (700) @(posedge aclk);
        $display("Run covered %0d error addresses and %0d results across seven settings.",
                 n_items, n_results);
        $display("Pages retired: %0d, table full answers: %0d, mismatches: %0d.",
                 n_retired, n_full, mismatches);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("PASS ce_page_retirement_tracker_unit");
        end else begin
            $display("FAIL ce_page_retirement_tracker_unit");
        end
        $finish;
    end
endmodule

[files.f]
sv/cprt_pkg.sv
sv/cprt_cfg.sv
sv/ce_page_retirement_tracker_unit.sv
tb/sv/ce_page_retirement_tracker_unit_test.sv
